@@ sv/lcd_decimal_field_writer_macros.svh @@
// ----------------------------------------------------------------------------
// lcd decimal field writer assertion macros
// shared concurrent assertion forms for the block's own checks
// ----------------------------------------------------------------------------
`ifndef LCD_DECIMAL_FIELD_WRITER_MACROS_SVH
`define LCD_DECIMAL_FIELD_WRITER_MACROS_SVH

// same-cycle implication, off while in reset
`define LDFW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, off while in reset
`define LDFW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ sv/ldfw_pkg.sv @@
// ----------------------------------------------------------------------------
// ldfw_pkg
// types, constants and digit helpers of the lcd decimal field writer
// ----------------------------------------------------------------------------
package ldfw_pkg;

  localparam int unsigned MAX_BYTES = 6;

  localparam logic [7:0] CMD_HOME   = 8'h80;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] CHAR_ERROR = 8'h45;
  localparam logic [3:0] MAX_DIGITS = 4'd5;

  localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

  // floor(v / 100) for any 16-bit v as (v * Q100_MUL) >> Q100_SHIFT
  localparam logic [32:0] Q100_MUL   = 33'd83887;
  localparam int unsigned Q100_SHIFT = 23;

  typedef logic [2:0] count_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] code;
  } lcd_byte_t;

  typedef struct packed {
    count_t                        cnt;
    lcd_byte_t [MAX_BYTES-1:0]     bytes;
  } job_t;

  // tens and units of a value below 100, returned as {tens, units}
  function automatic logic [7:0] tens_units(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = 15'(x) * 15'd205;
    tens = prod[14:11];
    rem  = x - 7'(tens) * 7'd10;
    return {tens, rem[3:0]};
  endfunction

endpackage

@@ sv/ldfw_serializer.sv @@
// ----------------------------------------------------------------------------
// ldfw_serializer
// holds one byte list and hands it out one byte per transfer
// ----------------------------------------------------------------------------
`include "lcd_decimal_field_writer_macros.svh"

module ldfw_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_valid,
  output logic               load_ready,
  input  ldfw_pkg::job_t     load_job,
  output logic               out_valid,
  input  logic               out_ready,
  output ldfw_pkg::lcd_byte_t out_byte,
  output logic               out_last
);

  logic                                          valid_r;
  logic                                          valid_nxt;
  ldfw_pkg::count_t                              cnt_r;
  ldfw_pkg::count_t                              idx_r;
  ldfw_pkg::count_t                              idx_nxt;
  ldfw_pkg::lcd_byte_t [ldfw_pkg::MAX_BYTES-1:0] bytes_r;
  logic                                          pop;
  logic                                          done;
  logic                                          load;

  assign out_last   = (idx_r == cnt_r - 3'd1);
  assign pop        = valid_r && out_ready;
  assign done       = pop && out_last;
  assign load_ready = !valid_r || done;
  assign load       = load_valid && load_ready;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (done) begin
      valid_nxt = 1'b0;
    end else if (pop) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
      if (load) begin
        cnt_r <= load_job.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= load_job.bytes;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = bytes_r[idx_r];

  `LDFW_ASSERT_IMPLY(idx_in_range, clk, rst_n, valid_r, idx_r < cnt_r)
  `LDFW_ASSERT_NEXT(held_until_last, clk, rst_n, valid_r && !(out_ready && out_last), valid_r && (cnt_r == $past(cnt_r)))
  `LDFW_ASSERT_IMPLY(load_not_empty, clk, rst_n, load, (load_job.cnt != '0) && (load_job.cnt <= 3'(ldfw_pkg::MAX_BYTES)))

endmodule

@@ sv/lcd_decimal_field_writer.sv @@
// ----------------------------------------------------------------------------
// lcd_decimal_field_writer
// turns a row, column, value and digit count into character lcd bytes
// ----------------------------------------------------------------------------
// One request per input transfer; each request yields a cursor command byte
// (home, rows one to four, none for rows five to seven) followed by up to five
// ascii decimal digits or a single 'E', one byte per output transfer with
// tlast on the final byte. A request passes an input register and two
// conversion registers before its bytes are loaded into the byte serializer,
// so its first byte is offered only once it has passed all three. A request
// yields one to six bytes, and a request with no bytes is dropped at the second
// conversion register without a load; the byte serializer, which sends one
// byte per cycle while out_tready is high, sets the sustained rate. New
// requests are accepted every cycle while it keeps up.

module lcd_decimal_field_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row[2:0], column[10:3], value[26:11], digits[30:27]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // byte_out[7:0]
  output logic        out_tlast,
  output logic        out_tuser   // is_data[0]
);

  // input register
  logic        a_valid_r;
  logic [2:0]  a_row_r;
  logic [7:0]  a_column_r;
  logic [15:0] a_value_r;
  logic [3:0]  a_digits_r;
  logic        a_ready;

  // first conversion register
  logic        b_valid_r;
  logic        b_has_cmd_r;
  logic [7:0]  b_cmd_r;
  logic        b_err_r;
  logic [2:0]  b_nd_r;
  logic [15:0] b_value_r;
  logic [9:0]  b_q100_r;
  logic        b_ready;

  // second conversion register
  logic        c_valid_r;
  logic        c_has_cmd_r;
  logic [7:0]  c_cmd_r;
  logic        c_err_r;
  logic [2:0]  c_nd_r;
  logic [6:0]  c_r100_r;
  logic [6:0]  c_r2_r;
  logic [2:0]  c_d4_r;
  logic        c_ready;
  logic        c_adv;

  logic        home;
  logic        has_cmd;
  logic [2:0]  row_m1;
  logic [7:0]  cmd;
  logic [32:0] q_prod;
  logic [15:0] r100_full;
  logic [2:0]  d4;
  logic [9:0]  r2_full;
  logic [7:0]  lo_pair;
  logic [7:0]  hi_pair;
  logic [3:0]  dig [5];

  ldfw_pkg::job_t      job;
  logic                ser_ready;
  logic                load_valid;
  ldfw_pkg::lcd_byte_t ser_byte;

  // handshake chain
  assign c_adv     = c_valid_r && ((job.cnt == '0) || ser_ready);
  assign c_ready   = !c_valid_r || c_adv;
  assign b_ready   = !b_valid_r || c_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_tready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_tvalid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && a_ready) begin
      a_row_r    <= in_tdata[2:0];
      a_column_r <= in_tdata[10:3];
      a_value_r  <= in_tdata[26:11];
      a_digits_r <= in_tdata[30:27];
    end
  end

  // cursor command and hundreds quotient
  assign home    = (a_row_r == 3'd0) || (a_column_r == 8'd0);
  assign has_cmd = home || (a_row_r <= 3'd4);
  assign row_m1  = a_row_r - 3'd1;
  assign cmd     = home ? ldfw_pkg::CMD_HOME
                        : ldfw_pkg::ROW_BASE[row_m1[1:0]] + a_column_r - 8'd1;
  assign q_prod  = 33'(a_value_r) * ldfw_pkg::Q100_MUL;

  always_ff @(posedge clk) begin
    if (a_valid_r && b_ready) begin
      b_has_cmd_r <= has_cmd;
      b_cmd_r     <= cmd;
      b_err_r     <= (a_digits_r > ldfw_pkg::MAX_DIGITS);
      b_nd_r      <= a_digits_r[2:0];
      b_value_r   <= a_value_r;
      b_q100_r    <= q_prod[ldfw_pkg::Q100_SHIFT +: 10];
    end
  end

  // remainders and leading digit
  assign r100_full = b_value_r - 16'(b_q100_r) * 16'd100;

  always_comb begin
    if (b_q100_r >= 10'd600) begin
      d4 = 3'd6;
    end else if (b_q100_r >= 10'd500) begin
      d4 = 3'd5;
    end else if (b_q100_r >= 10'd400) begin
      d4 = 3'd4;
    end else if (b_q100_r >= 10'd300) begin
      d4 = 3'd3;
    end else if (b_q100_r >= 10'd200) begin
      d4 = 3'd2;
    end else if (b_q100_r >= 10'd100) begin
      d4 = 3'd1;
    end else begin
      d4 = 3'd0;
    end
  end

  assign r2_full = b_q100_r - 10'(d4) * 10'd100;

  always_ff @(posedge clk) begin
    if (b_valid_r && c_ready) begin
      c_has_cmd_r <= b_has_cmd_r;
      c_cmd_r     <= b_cmd_r;
      c_err_r     <= b_err_r;
      c_nd_r      <= b_nd_r;
      c_r100_r    <= r100_full[6:0];
      c_r2_r      <= r2_full[6:0];
      c_d4_r      <= d4;
    end
  end

  // byte list
  assign lo_pair = ldfw_pkg::tens_units(c_r100_r);
  assign hi_pair = ldfw_pkg::tens_units(c_r2_r);
  assign dig[0]  = lo_pair[3:0];
  assign dig[1]  = lo_pair[7:4];
  assign dig[2]  = hi_pair[3:0];
  assign dig[3]  = hi_pair[7:4];
  assign dig[4]  = {1'b0, c_d4_r};

  always_comb begin
    logic [2:0] t;
    logic [2:0] pos;
    job.cnt = 3'(c_has_cmd_r) + (c_err_r ? 3'd1 : c_nd_r);
    for (int j = 0; j < ldfw_pkg::MAX_BYTES; j++) begin
      t   = 3'(j) - 3'(c_has_cmd_r);
      pos = c_nd_r - 3'd1 - t;
      if (c_has_cmd_r && (j == 0)) begin
        job.bytes[j] = {1'b0, c_cmd_r};
      end else if (c_err_r) begin
        job.bytes[j] = {1'b1, ldfw_pkg::CHAR_ERROR};
      end else if (pos < 3'd5) begin
        job.bytes[j] = {1'b1, ldfw_pkg::ASCII_ZERO + {4'd0, dig[pos]}};
      end else begin
        job.bytes[j] = {1'b1, ldfw_pkg::ASCII_ZERO};
      end
    end
  end

  assign load_valid = c_valid_r && (job.cnt != '0);

  ldfw_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load_valid),
    .load_ready (ser_ready),
    .load_job   (job),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (ser_byte),
    .out_last   (out_tlast)
  );

  assign out_tdata = ser_byte.code;
  assign out_tuser = ser_byte.is_data;

endmodule

@@ tb/lcd_decimal_field_writer_tb.sv @@
// ----------------------------------------------------------------------------
// lcd_decimal_field_writer_tb
// self-checking bench for the lcd decimal field writer
// ----------------------------------------------------------------------------
// Requests are streamed into the block and the byte sequence each one should
// produce is predicted on acceptance: a cursor command (home, rows one to
// four, none for rows five to seven) then the decimal digits, a single 'E' or
// nothing. Every output transfer is checked against the oldest predicted byte.
// Directed cases cover the cursor and digit corner cases and empty requests;
// random requests follow with random gaps on both sides, a stretch without
// gaps, and a long receiver stall that backs the block up to its input.

module lcd_decimal_field_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_LEN    = 200;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic       is_data;
    logic [7:0] code;
    logic       last;
  } lcd_out_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;    // row[2:0], column[10:3], value[26:11], digits[30:27]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // byte_out[7:0]
  logic        out_tlast;
  logic        out_tuser;          // is_data[0]

  logic        idle_en    = 1'b1;
  logic        hold_req   = 1'b0;
  int          hold_cycles = 0;
  int          stall_cycles = 0;
  int          mismatch_count = 0;
  lcd_out_t    lcd_expect_q [$];
  lcd_out_t    want_byte;

  lcd_decimal_field_writer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // bytes a request should produce, appended to the expectation queue
  function automatic void predict_bytes(input logic [2:0] row, input logic [7:0] column,
                                        input logic [15:0] value, input logic [3:0] digits);
    lcd_out_t   seq [$];
    logic [7:0] cmd;
    int         i;
    int         div;
    int         d;
    if (row == 3'd0 || column == 8'd0) begin
      seq.push_back('{1'b0, ldfw_pkg::CMD_HOME, 1'b0});
    end else if (row <= 3'd4) begin
      cmd = ldfw_pkg::ROW_BASE[2'(row - 3'd1)] + column - 8'd1;
      seq.push_back('{1'b0, cmd, 1'b0});
    end
    if (digits > ldfw_pkg::MAX_DIGITS) begin
      seq.push_back('{1'b1, ldfw_pkg::CHAR_ERROR, 1'b0});
    end else begin
      for (i = int'(digits); i > 0; i--) begin
        div = 1;
        repeat (i - 1) div = div * 10;
        if (i == int'(ldfw_pkg::MAX_DIGITS)) d = int'(value) / 10000;
        else d = (int'(value) / div) % 10;
        seq.push_back('{1'b1, 8'(int'(ldfw_pkg::ASCII_ZERO) + d), 1'b0});
      end
    end
    if (seq.size() > 0) seq[seq.size() - 1].last = 1'b1;
    foreach (seq[k]) lcd_expect_q.push_back(seq[k]);
  endfunction

  task automatic send_request(input logic [2:0] row, input logic [7:0] column,
                              input logic [15:0] value, input logic [3:0] digits);
    while (idle_en && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, digits, value, column, row};
    do @(posedge clk); while (!in_tready);
    predict_bytes(row, column, value, digits);
  endtask

  task automatic send_random(input int n);
    logic [2:0]  row;
    logic [7:0]  column;
    logic [15:0] value;
    logic [3:0]  digits;
    int          pick;
    repeat (n) begin
      row = 3'($urandom_range(7));
      pick = $urandom_range(9);
      if (pick == 0) column = 8'd0;
      else if (pick == 1) column = 8'd255;
      else if (pick < 4) column = 8'($urandom_range(255));
      else column = 8'($urandom_range(20, 1));
      value = ($urandom_range(3) == 0) ? 16'($urandom_range(999)) : 16'($urandom_range(65535));
      pick = $urandom_range(19);
      if (pick < 15) digits = 4'($urandom_range(5, 1));
      else if (pick < 17) digits = 4'd0;
      else digits = 4'($urandom_range(15, 6));
      send_request(row, column, value, digits);
    end
  endtask

  task automatic test_cursor_commands;
    send_request(3'd0, 8'd0,   16'd7,     4'd1);
    send_request(3'd0, 8'd200, 16'd42,    4'd2);
    send_request(3'd6, 8'd0,   16'd9,     4'd1);
    send_request(3'd1, 8'd1,   16'd3,     4'd1);
    send_request(3'd2, 8'd1,   16'd3,     4'd1);
    send_request(3'd3, 8'd1,   16'd3,     4'd1);
    send_request(3'd4, 8'd1,   16'd3,     4'd1);
    send_request(3'd1, 8'd255, 16'd1,     4'd1);
    send_request(3'd4, 8'd255, 16'd1,     4'd1);
    send_request(3'd5, 8'd7,   16'd8,     4'd2);
    send_request(3'd7, 8'd255, 16'd65535, 4'd3);
  endtask

  task automatic test_digit_counts;
    send_request(3'd1, 8'd3,  16'd65535, 4'd5);
    send_request(3'd2, 8'd4,  16'd0,     4'd5);
    send_request(3'd3, 8'd5,  16'd12345, 4'd1);
    send_request(3'd3, 8'd5,  16'd12345, 4'd2);
    send_request(3'd3, 8'd5,  16'd12345, 4'd3);
    send_request(3'd3, 8'd5,  16'd12345, 4'd4);
    send_request(3'd4, 8'd9,  16'd500,   4'd0);
    send_request(3'd2, 8'd16, 16'd77,    4'd6);
    send_request(3'd1, 8'd20, 16'd65535, 4'd15);
  endtask

  task automatic test_empty_request;
    send_request(3'd5, 8'd9, 16'd1234,  4'd0);
    send_request(3'd7, 8'd1, 16'd65535, 4'd0);
  endtask

  task automatic test_random_requests;
    send_random(150);
  endtask

  task automatic test_unthrottled_stream;
    idle_en <= 1'b0;
    send_random(30);
    idle_en <= 1'b1;
  endtask

  task automatic test_output_backpressure;
    hold_req <= 1'b1;
    idle_en  <= 1'b0;
    send_random(25);
    idle_en  <= 1'b1;
  endtask

  // receiver: random ready, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && hold_cycles < HOLD_LEN) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_tready <= idle_en ? ($urandom_range(99) >= 37) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (lcd_expect_q.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %h user %b last %b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatch_count++;
      end else begin
        want_byte = lcd_expect_q.pop_front();
        if (out_tuser !== want_byte.is_data) begin
          $display("%0t: is_data mismatch: expected %b, actual %b",
                   $time, want_byte.is_data, out_tuser);
          mismatch_count++;
        end
        if (out_tdata !== want_byte.code) begin
          $display("%0t: byte mismatch: expected %h, actual %h", $time, want_byte.code, out_tdata);
          mismatch_count++;
        end
        if (out_tlast !== want_byte.last) begin
          $display("%0t: last mismatch: expected %b, actual %b", $time, want_byte.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_cursor_commands();
    test_digit_counts();
    test_empty_request();
    test_random_requests();
    test_unthrottled_stream();
    test_output_backpressure();
    in_tvalid <= 1'b0;
    while (lcd_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
